// ----- src/sbjl_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sbjl_pkg
// Shared types and constants for the sign-bit inner product estimator.
// ----------------------------------------------------------------------------
package sbjl_pkg;

  // Field and state widths.
  localparam int QUERY_W = 32;
  localparam int NORM_W  = 32;
  localparam int SCALE_W = 32;
  localparam int PW_W    = 13;
  localparam int ACC_W   = 44;
  localparam int CNT_W   = 13;
  localparam int EST_W   = 48;
  localparam int LIMB_W  = 32;
  localparam int LIMBS   = 4;
  localparam int PROD_W  = LIMB_W * LIMBS;

  // Largest legal projection width.
  localparam int MAX_PROJ_WIDTH = 4096;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_PROJ_WIDTH     = 1'b0;
  localparam cfg_idx_t CFG_ESTIMATE_SCALE = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [PW_W-1:0]    PW_RESET    = 13'd1;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd2691471617;

  // Saturation limits of the element counter and of the estimate.
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [EST_W-1:0] EST_MAX = {1'b0, {(EST_W-1){1'b1}}};
  localparam logic [EST_W-1:0] EST_MIN = {1'b1, {(EST_W-1){1'b0}}};

  // Rounding: half of one output LSB at product bit 46.
  localparam int RND_POS = 46;
  localparam int Q_LSB   = 47;
  localparam int Q_W     = 64;

  // Depth of the job queue between front and back.
  localparam int JOB_DEPTH = 2;
  localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
  localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

  // One finished accumulation that waits for scaling.
  typedef struct packed {
    logic signed [ACC_W-1:0] acc_value;
    logic [NORM_W-1:0]       key_norm;
    logic                    length_error;
  } job_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    B_IDLE,
    B_MUL,
    B_ROUND,
    B_SAT
  } back_state_t;

endpackage
`default_nettype wire

// ----- src/sbjl_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sbjl_front
// Accepts query elements, keeps the saturating signed sum and the element
// count, and hands a finished sum to the job queue on the last element.
// ----------------------------------------------------------------------------
module sbjl_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic signed [sbjl_pkg::QUERY_W-1:0] query_value,
  input  logic                                sign_bit,
  input  logic [sbjl_pkg::NORM_W-1:0]         key_norm,
  input  logic                                last,
  input  logic [sbjl_pkg::PW_W-1:0]           proj_width,
  output logic                                job_valid,
  input  logic                                job_ready,
  output sbjl_pkg::job_t                      job
);
  import sbjl_pkg::*;

  logic signed [ACC_W-1:0] accumulator;
  logic [CNT_W-1:0]        element_count;
  logic                    accept;
  logic signed [ACC_W:0]   sum_wide;
  logic signed [ACC_W:0]   value_ext;
  logic signed [ACC_W-1:0] sum_sat;
  logic [CNT_W-1:0]        count_inc;
  logic                    bad_width;

  // The holding register frees up when the queue takes its request.
  assign full   = job_valid && !job_ready;
  assign accept = push && !full;

  // Saturating add or subtract of the element.
  always_comb begin
    value_ext = (ACC_W+1)'(query_value);
    sum_wide  = sign_bit ? ((ACC_W+1)'(accumulator) - value_ext)
                         : ((ACC_W+1)'(accumulator) + value_ext);
    if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
      sum_sat = sum_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[ACC_W-1:0];
    end
    count_inc = (element_count == CNT_MAX) ? element_count : element_count + 1'b1;
    bad_width = (proj_width == '0) || (proj_width > PW_W'(MAX_PROJ_WIDTH));
  end

  // Running sum and count; both clear after the last element.
  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator   <= '0;
      element_count <= '0;
    end else if (accept) begin
      if (last) begin
        accumulator   <= '0;
        element_count <= '0;
      end else begin
        accumulator   <= sum_sat;
        element_count <= count_inc;
      end
    end
  end

  // Holding register for the finished sum.
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (accept && last) begin
      job_valid <= 1'b1;
    end else if (job_ready) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last) begin
      job.acc_value    <= sum_sat;
      job.key_norm     <= key_norm;
      job.length_error <= bad_width || (count_inc != proj_width);
    end
  end

endmodule
`default_nettype wire

// ----- src/sbjl_job_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sbjl_job_fifo
// Short queue of finished sums between the front and the back.
// ----------------------------------------------------------------------------
module sbjl_job_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  output logic           full,
  input  sbjl_pkg::job_t wr_data,
  input  logic           rd_en,
  output logic           empty,
  output sbjl_pkg::job_t rd_data
);
  import sbjl_pkg::*;

  job_t                 entries [JOB_DEPTH];
  logic [JOB_PTR_W-1:0] wr_ptr;
  logic [JOB_PTR_W-1:0] rd_ptr;
  logic [JOB_CNT_W-1:0] fill;
  logic                 do_wr;
  logic                 do_rd;

  assign full    = (fill == JOB_CNT_W'(JOB_DEPTH));
  assign empty   = (fill == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entries[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        fill <= fill + 1'b1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// ----- src/sbjl_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sbjl_back
// Scales one finished sum by the key norm and the scale with a shared
// 32x32 multiplier, one limb per cycle, then rounds, saturates and holds
// the result for the consumer.
// ----------------------------------------------------------------------------
module sbjl_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              job_empty,
  input  sbjl_pkg::job_t                    job,
  output logic                              job_pop,
  input  logic [sbjl_pkg::SCALE_W-1:0]      estimate_scale,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [sbjl_pkg::EST_W-1:0] estimate,
  output logic                              saturated,
  output logic                              length_error
);
  import sbjl_pkg::*;

  back_state_t         state, state_next;
  logic [2:0]          step, step_next;
  logic [PROD_W-1:0]   limbs, limbs_next;
  logic [LIMB_W-1:0]   carry, carry_next;
  logic [PROD_W-1:0]   rounded, rounded_next;
  logic [NORM_W-1:0]   norm, norm_next;
  logic                neg, neg_next;
  logic                lerr, lerr_next;
  logic                res_valid, res_valid_next;
  logic                res_write;
  logic [ACC_W-1:0]    mag;
  logic [LIMB_W-1:0]   factor;
  logic [2*LIMB_W-1:0] prod;
  logic                ovf;
  logic [Q_W-1:0]      q;
  logic                sat;
  logic [EST_W-1:0]    est_value;

  assign empty = !res_valid;

  // Magnitude of the incoming signed sum.
  assign mag = job.acc_value[ACC_W-1] ? ACC_W'(-job.acc_value) : job.acc_value;

  // One limb times the current factor plus the carry from the limb below.
  assign factor = step[2] ? estimate_scale : norm;
  assign prod   = ((2*LIMB_W)'(limbs[LIMB_W-1:0]) * (2*LIMB_W)'(factor))
                + (2*LIMB_W)'(carry);

  // Saturation of the rounded magnitude.
  always_comb begin
    ovf = |rounded[PROD_W-1:Q_LSB+Q_W];
    q   = rounded[Q_LSB+Q_W-1:Q_LSB];
    if (neg) begin
      sat       = ovf || (q > Q_W'(EST_MIN));
      est_value = sat ? EST_MIN : EST_W'(-q[EST_W-1:0]);
    end else begin
      sat       = ovf || (q > Q_W'(EST_MAX));
      est_value = sat ? EST_MAX : q[EST_W-1:0];
    end
  end

  // Sequencer: load, eight limb steps, round, write out.
  always_comb begin
    state_next   = state;
    step_next    = step;
    limbs_next   = limbs;
    carry_next   = carry;
    rounded_next = rounded;
    norm_next    = norm;
    neg_next     = neg;
    lerr_next    = lerr;
    job_pop      = 1'b0;
    res_write    = 1'b0;
    case (state)
      B_IDLE: begin
        if (!job_empty) begin
          job_pop    = 1'b1;
          limbs_next = PROD_W'(mag);
          carry_next = '0;
          step_next  = '0;
          norm_next  = job.key_norm;
          neg_next   = job.acc_value[ACC_W-1];
          lerr_next  = job.length_error;
          state_next = B_MUL;
        end
      end
      B_MUL: begin
        limbs_next = {prod[LIMB_W-1:0], limbs[PROD_W-1:LIMB_W]};
        carry_next = (step[1:0] == 2'd3) ? '0 : prod[2*LIMB_W-1:LIMB_W];
        step_next  = step + 1'b1;
        if (step == 3'd7) begin
          state_next = B_ROUND;
        end
      end
      B_ROUND: begin
        rounded_next = limbs + (PROD_W'(1) << RND_POS);
        state_next   = B_SAT;
      end
      B_SAT: begin
        if (!res_valid || pop) begin
          res_write  = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
    res_valid_next = (res_valid && !pop) || res_write;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      step      <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      res_valid <= res_valid_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    limbs   <= limbs_next;
    carry   <= carry_next;
    rounded <= rounded_next;
    norm    <= norm_next;
    neg     <= neg_next;
    lerr    <= lerr_next;
    if (res_write) begin
      estimate     <= est_value;
      saturated    <= sat;
      length_error <= lerr;
    end
  end

endmodule
`default_nettype wire

// ----- src/sign_bit_jl_inner_product_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sign_bit_jl_inner_product_unit
// Sign-bit projection inner product estimator: signed sum of query elements
// steered by key sign bits, scaled by key norm and a programmable scale.
// ----------------------------------------------------------------------------
//  Channel   Handshake          Payload
//  -------   ----------------   ------------------------------------------
//  input     push / full        query_value, sign_bit, key_norm, last
//  result    empty / pop        estimate, saturated, length_error
//  config    cfg_we             cfg_index, cfg_data (no read-back)
//
//  The front takes one element per cycle while full is low; only the element
//  marked last creates a request for the back end.
//  The back end works on one request at a time: load, eight limb steps on its
//  single 32x32 multiplier, round, and write to the result register.
//  A two-entry queue sits between front and back; full rises only when that
//  queue and the front holding register are both occupied.
//  Reset is synchronous with no clearing pass.
// ----------------------------------------------------------------------------
module sign_bit_jl_inner_product_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic signed [sbjl_pkg::QUERY_W-1:0] query_value,
  input  logic                                sign_bit,
  input  logic [sbjl_pkg::NORM_W-1:0]         key_norm,
  input  logic                                last,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [sbjl_pkg::EST_W-1:0]   estimate,
  output logic                                saturated,
  output logic                                length_error,
  input  logic                                cfg_we,
  input  sbjl_pkg::cfg_idx_t                  cfg_index,
  input  logic [sbjl_pkg::SCALE_W-1:0]        cfg_data
);
  import sbjl_pkg::*;

  logic [PW_W-1:0]    proj_width;
  logic [SCALE_W-1:0] estimate_scale;
  logic               front_valid;
  logic               fifo_full;
  logic               fifo_empty;
  logic               fifo_pop;
  job_t               front_job;
  job_t               fifo_job;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      proj_width     <= PW_RESET;
      estimate_scale <= SCALE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PROJ_WIDTH:     proj_width     <= cfg_data[PW_W-1:0];
        CFG_ESTIMATE_SCALE: estimate_scale <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Front: accumulation and counting.
  sbjl_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .query_value (query_value),
    .sign_bit    (sign_bit),
    .key_norm    (key_norm),
    .last        (last),
    .proj_width  (proj_width),
    .job_valid   (front_valid),
    .job_ready   (!fifo_full),
    .job         (front_job)
  );

  // Queue of finished sums.
  sbjl_job_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (front_valid),
    .full    (fifo_full),
    .wr_data (front_job),
    .rd_en   (fifo_pop),
    .empty   (fifo_empty),
    .rd_data (fifo_job)
  );

  // Back: scaling, rounding and result register.
  sbjl_back u_back (
    .clk            (clk),
    .rst            (rst),
    .job_empty      (fifo_empty),
    .job            (fifo_job),
    .job_pop        (fifo_pop),
    .estimate_scale (estimate_scale),
    .empty          (empty),
    .pop            (pop),
    .estimate       (estimate),
    .saturated      (saturated),
    .length_error   (length_error)
  );

endmodule
`default_nettype wire

// ----- src/sbjl_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sbjl_checker
// Port-level checks for the inner product estimator, bound to the top level.
// ----------------------------------------------------------------------------
module sbjl_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                full,
  input logic                                empty,
  input logic                                pop,
  input logic signed [sbjl_pkg::EST_W-1:0]   estimate,
  input logic                                saturated,
  input logic                                length_error
);
  import sbjl_pkg::*;

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result pending after reset");

  // Reset leaves room for input.
  a_reset_not_full: assert property (@(posedge clk) rst |=> !full)
    else $error("input full after reset");

  // A clipped estimate sits at one of the two limits.
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    (!empty && saturated) |-> (estimate == EST_MAX || estimate == EST_MIN))
    else $error("saturated estimate not at a limit");

  // A waiting result holds until it is taken.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(estimate) && $stable(saturated)
                          && $stable(length_error)))
    else $error("waiting result changed");

endmodule

bind sign_bit_jl_inner_product_unit sbjl_checker u_sbjl_checker (
  .clk          (clk),
  .rst          (rst),
  .full         (full),
  .empty        (empty),
  .pop          (pop),
  .estimate     (estimate),
  .saturated    (saturated),
  .length_error (length_error)
);
`default_nettype wire
